FILE: design/gb3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared widths, register map, reset values, kernel weights and the control
// bundle for the 3x3 Gaussian blur stream.
// ----------------------------------------------------------------------------
package gb3_pkg;

	localparam int PIX_W   = 8;
	localparam int DIM_W   = 11;
	localparam int SHIFT_W = 4;
	localparam int FILT_W  = 12;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 2;

	// Largest value an 11-bit geometry register can hold.
	localparam int DIM_MAX = 2047;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// Register indexes (byte address divided by four).
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_SHIFT  = 2'd2;

	localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd1024;
	localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd1024;
	localparam logic [SHIFT_W-1:0] SHIFT_RST  = 4'd4;

	// One-dimensional kernel; the 3x3 kernel is its outer product.
	localparam logic [1:0] ROW_WEIGHT [3] = '{2'd1, 2'd2, 2'd1};

	// Effective configuration after clamping.
	typedef struct packed {
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [SHIFT_W-1:0] shift;
	} cfg_t;

	// Per-item control carried from the accept stage to the window stage.
	typedef struct packed {
		logic emit;     // this item produces an output pixel
		logic last;     // that output is the final one of the frame
		logic top_x;    // top neighbour row lies outside the frame
		logic bot_x;    // bottom neighbour row lies outside the frame
		logic left_x;   // left neighbour column lies outside the frame
		logic right_x;  // right neighbour column lies outside the frame
	} tap_ctl_t;

endpackage

FILE: design/gb3_stream_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3 stream interfaces
// Valid/ready channels for input pixels and filtered output pixels.
// ----------------------------------------------------------------------------
interface gb3_pix_in_if import gb3_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PIX_W-1:0] pixel;

	modport source (output valid, output cmd, output pixel, input ready);
	modport sink   (input valid, input cmd, input pixel, output ready);
endinterface

interface gb3_pix_out_if import gb3_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FILT_W-1:0] filtered;
	logic              last;

	modport source (output valid, output filtered, output last, input ready);
	modport sink   (input valid, input filtered, input last, output ready);
endinterface

FILE: design/gb3_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_cfg_regs
// APB register file: frame geometry and sum shift, clamped geometry and the
// registered pixel count of one frame.
// ----------------------------------------------------------------------------
module gb3_cfg_regs import gb3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int CW         = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg,
	output logic [CW-1:0]     total,
	output logic              geom_wr
);

	localparam logic [DIM_W-1:0] WMAX_V =
		(MAX_WIDTH >= DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HMAX_V =
		(MAX_HEIGHT >= DIM_MAX) ? DIM_W'(DIM_MAX) : DIM_W'(MAX_HEIGHT);

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [CW-1:0]      total_q;
	logic [IDX_W-1:0]   idx;
	logic               wr;
	logic [2*DIM_W-1:0] prod;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			shift_q  <= SHIFT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_SHIFT:  shift_q  <= pwdata[SHIFT_W-1:0];
				default:    ;
			endcase
		end
	end

	assign geom_wr = wr && ((idx == REG_WIDTH) || (idx == REG_HEIGHT));

	always_comb begin
		unique case (idx)
			REG_WIDTH:  prdata = DATA_W'(width_q);
			REG_HEIGHT: prdata = DATA_W'(height_q);
			REG_SHIFT:  prdata = DATA_W'(shift_q);
			default:    prdata = '0;
		endcase
	end

	// A zero dimension acts as one, anything above the maximum as the maximum.
	always_comb begin
		cfg.w = (width_q == '0) ? DIM_W'(1) : ((width_q > WMAX_V) ? WMAX_V : width_q);
		cfg.h = (height_q == '0) ? DIM_W'(1) : ((height_q > HMAX_V) ? HMAX_V : height_q);
		cfg.shift = shift_q;
	end

	assign prod = cfg.w * cfg.h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= CW'(WIDTH_RST) * CW'(HEIGHT_RST);
		end else begin
			total_q <= CW'(prod);
		end
	end

	assign total = total_q;

endmodule

FILE: design/gb3_pos_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_pos_div
// Restoring divider, one quotient bit per cycle. Splits the input count into
// row and column after a write to the frame width or height.
// ----------------------------------------------------------------------------
module gb3_pos_div import gb3_pkg::*; #(
	parameter int CW = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CW-1:0]    dividend,
	input  logic [DIM_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DIM_W-1:0] rem,
	output logic [CW-1:0]    quo
);

	localparam int CNT_W = $clog2(CW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [CW-1:0]    dvd_q;
	logic [DIM_W-1:0] rem_q;
	logic [CW-1:0]    quo_q;
	logic [DIM_W:0]   trial;
	logic [DIM_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[CW-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(CW);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
			quo_q <= {quo_q[CW-2:0], ge};
		end
	end

	assign busy = (cnt_q != '0) || done_q;
	assign done = done_q;
	assign rem  = rem_q;
	assign quo  = quo_q;

endmodule

FILE: design/gb3_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_line_ram
// One line store: single write port, single registered read port, with the
// write data forwarded when both ports hit the same column in one cycle.
// ----------------------------------------------------------------------------
module gb3_line_ram import gb3_pkg::*; #(
	parameter int DEPTH = MAX_WIDTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [PIX_W-1:0] wdata,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/gb3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_window
// 3x3 pixel window and the weighted kernel sum with frame-edge masking.
// ----------------------------------------------------------------------------
module gb3_window import gb3_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift_en,
	input  logic [PIX_W-1:0]   top_new,
	input  logic [PIX_W-1:0]   mid_new,
	input  logic [PIX_W-1:0]   bot_new,
	input  tap_ctl_t           ctl,
	input  logic [SHIFT_W-1:0] shift,
	output logic [FILT_W-1:0]  filtered
);

	localparam int RS_W = PIX_W + 2;

	logic [PIX_W-1:0] win_q [3][3];
	logic [PIX_W-1:0] tap   [3][3];
	logic [PIX_W-1:0] new_col [3];
	logic [2:0]       col_on;
	logic [2:0]       row_on;
	logic [RS_W-1:0]  rs [3];
	logic [FILT_W-1:0] sum;

	assign new_col[0] = top_new;
	assign new_col[1] = mid_new;
	assign new_col[2] = bot_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (shift_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= new_col[r];
			end
		end
	end

	// The window as it stands after this item's column has moved in.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			tap[r][0] = win_q[r][1];
			tap[r][1] = win_q[r][2];
			tap[r][2] = new_col[r];
		end
	end

	assign col_on = {!ctl.right_x, 1'b1, !ctl.left_x};
	assign row_on = {!ctl.bot_x, 1'b1, !ctl.top_x};

	always_comb begin
		sum = '0;
		for (int r = 0; r < 3; r++) begin
			rs[r] = '0;
			for (int c = 0; c < 3; c++) begin
				if (col_on[c]) begin
					rs[r] = rs[r] + RS_W'(tap[r][c]) * RS_W'(ROW_WEIGHT[c]);
				end
			end
			if (row_on[r]) begin
				sum = sum + FILT_W'(rs[r]) * FILT_W'(ROW_WEIGHT[r]);
			end
		end
	end

	assign filtered = sum >> shift;

endmodule

FILE: design/gaussian_blur_3x3_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream
// 3x3 Gaussian blur (1 2 1 / 2 4 2 / 1 2 1) over a raster pixel stream with
// two line stores, zero padding at the frame edges and a programmable shift.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock cycle while its input ready is high
// and gives at most one filtered pixel per input transfer. A pixel transfer
// (cmd 0) carrying raster index k produces the output for index k - width - 1;
// once the frame is complete, every further transfer acts as a drain and
// flushes the remaining width + 1 outputs, while a drain (cmd 1) sent before
// the frame is complete is dropped. The final output of a frame has last set,
// after which the block is ready for the next frame. An output pixel passes
// through the window stage register into the output register, and the next
// input is taken while that result waits, so a stalled output stops input
// only when a second result is ready behind it. After any write to the width
// or height register the input ready stays low while a one-bit-per-cycle
// divider re-derives the current row and column from the pixel count. The
// line stores are not cleared at reset; their first row of reads is masked
// by the frame-edge logic. The user must write configuration only while no
// output is pending; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream import gb3_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	gb3_pix_in_if.sink        pix_in,
	gb3_pix_out_if.source     pix_out
);

	localparam int WMAX = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
	localparam int HMAX = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
	// Count width: enough for a full frame plus the flush tail.
	localparam int CW   = $clog2(WMAX * HMAX + WMAX + 2);
	localparam int CLW  = $clog2(MAX_WIDTH);

	cfg_t              cfg;
	logic [CW-1:0]     total;
	logic              geom_wr;

	logic              div_busy;
	logic              div_done;
	logic [DIM_W-1:0]  div_rem;
	logic [CW-1:0]     div_quo;

	// Position of the next input pixel in the frame.
	logic [CW-1:0]     p_q;
	logic [CW-1:0]     row_q;
	logic [CLW-1:0]    col_q;

	logic [CW-1:0]     w_ext;
	logic [CW-1:0]     h_ext;
	logic [CW-1:0]     thr_last;
	logic              in_frame;
	logic              past_w;
	logic              emit;
	logic              last;
	logic              rearm;
	logic              col_wrap;
	logic              c0;
	logic              c1;
	tap_ctl_t          ctl_next;

	logic              in_ready;
	logic              in_fire;
	logic              proc;

	logic              valid_s1;
	logic [PIX_W-1:0]  pixel_s1;
	logic [CLW-1:0]    col_s1;
	tap_ctl_t          ctl_s1;
	logic              s1_fire;

	logic [PIX_W-1:0]  older_rd;
	logic [PIX_W-1:0]  newer_rd;
	logic [FILT_W-1:0] filtered;

	logic              out_valid_q;
	logic [FILT_W-1:0] filt_q;
	logic              last_q;

	gb3_cfg_regs #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CW         (CW)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.total   (total),
		.geom_wr (geom_wr)
	);

	// Re-split the pixel count into row and column whenever the geometry moves.
	gb3_pos_div #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (geom_wr),
		.dividend (p_q),
		.divisor  (cfg.w),
		.busy     (div_busy),
		.done     (div_done),
		.rem      (div_rem),
		.quo      (div_quo)
	);

	// ------------------------------------------------------------------
	// Accept stage: classify the transfer and advance the position.
	// ------------------------------------------------------------------
	assign w_ext    = CW'(cfg.w);
	assign h_ext    = CW'(cfg.h);
	assign thr_last = total + w_ext;

	assign in_frame = p_q < total;
	assign past_w   = p_q > w_ext;
	// Output index q = p - w - 1 must still lie inside the frame.
	assign emit     = past_w && (p_q < (thr_last + CW'(1)));
	assign last     = emit && (p_q == thr_last);
	// Re-arm after the final output, or when the output index has run past
	// the frame because the geometry shrank mid-frame.
	assign rearm    = (past_w && !emit) || last;

	assign col_wrap = (CW'(col_q) + CW'(1)) == w_ext;
	assign c0       = col_q == '0;
	assign c1       = col_q == CLW'(1);

	// The output pixel sits one row up and one column left of the input.
	always_comb begin
		ctl_next.emit    = emit;
		ctl_next.last    = last;
		ctl_next.top_x   = c0 ? (row_q == CW'(2)) : (row_q == CW'(1));
		ctl_next.bot_x   = row_q >= (h_ext + CW'(c0));
		ctl_next.left_x  = c1 || (c0 && (cfg.w == DIM_W'(1)));
		ctl_next.right_x = c0;
	end

	assign s1_fire  = valid_s1 && (!ctl_s1.emit || !out_valid_q || pix_out.ready);
	assign in_ready = !div_busy && (!valid_s1 || s1_fire);
	assign in_fire  = pix_in.valid && in_ready;
	// A drain before the frame is complete is dropped without effect.
	assign proc     = in_fire && !(in_frame && pix_in.cmd);

	assign pix_in.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (div_done) begin
			row_q <= div_quo;
			col_q <= CLW'(div_rem);
		end else if (proc) begin
			if (rearm) begin
				p_q   <= '0;
				row_q <= '0;
				col_q <= '0;
			end else begin
				p_q <= p_q + CW'(1);
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + CW'(1);
				end else begin
					col_q <= col_q + CLW'(1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Window stage: line store data is back, shift the window, write the
	// stores and form the weighted sum.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (proc) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			pixel_s1 <= in_frame ? pix_in.pixel : '0;
			col_s1   <= col_q;
			ctl_s1   <= ctl_next;
		end
	end

	gb3_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (CLW)
	) u_newer (
		.clk   (clk),
		.re    (proc),
		.raddr (col_q),
		.we    (s1_fire),
		.waddr (col_s1),
		.wdata (pixel_s1),
		.rdata (newer_rd)
	);

	// The older store takes over what the newer store held for that column.
	gb3_line_ram #(
		.DEPTH (MAX_WIDTH),
		.AW    (CLW)
	) u_older (
		.clk   (clk),
		.re    (proc),
		.raddr (col_q),
		.we    (s1_fire),
		.waddr (col_s1),
		.wdata (newer_rd),
		.rdata (older_rd)
	);

	gb3_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (s1_fire),
		.top_new  (older_rd),
		.mid_new  (newer_rd),
		.bot_new  (pixel_s1),
		.ctl      (ctl_s1),
		.shift    (cfg.shift),
		.filtered (filtered)
	);

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && ctl_s1.emit) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && ctl_s1.emit) begin
			filt_q <= filtered;
			last_q <= ctl_s1.last;
		end
	end

	assign pix_out.valid    = out_valid_q;
	assign pix_out.filtered = filt_q;
	assign pix_out.last     = last_q;

`ifndef NO_ASSERTIONS
	// Outside a divider pass the column always lies inside the row.
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		!div_busy |-> (CW'(col_q) < w_ext))
		else $error("column counter outside the frame width");

	// A result blocked behind a full output register must hold off input.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl_s1.emit && out_valid_q && !pix_out.ready) |-> !in_ready)
		else $error("input accepted while the window stage is blocked");

	// The final output of a frame leaves the counters re-armed.
	a_last_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && ctl_s1.last) |-> (p_q == '0))
		else $error("frame end without counter re-arm");
`endif

endmodule

FILE: verif/gaussian_blur_3x3_stream_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_stream_tb
// Self-checking bench for the 3x3 Gaussian blur stream. A behavioral model
// inside a small scoreboard class predicts every filtered pixel from the
// accepted input transfers and the programmed geometry. Output transfers are
// compared in order, field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_stream_tb;
	import gb3_pkg::*;

	// Line store depth of the block as instantiated with default parameters.
	localparam int LINE_DEPTH = MAX_WIDTH_DEF;
	localparam int ROW_LIMIT  = MAX_HEIGHT_DEF;

	// Number of consumed random transfers to aim for, the cycles allowed for
	// the block to settle after the last expected pixel, and the number of
	// cycles without any transfer that ends the run as hung.
	localparam int RANDOM_ITEMS = 550;
	localparam int SETTLE       = 6;
	localparam int STALL_LIMIT  = 4000;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} blur_cmd_e;

	typedef struct packed {
		logic [FILT_W-1:0] filtered;
		logic              last;
	} blur_px_t;

	// ------------------------------------------------------------------------
	// Scoreboard: a behavioral copy of the filter plus the queue of filtered
	// pixels that the block still owes.
	// ------------------------------------------------------------------------
	class blur_checker;
		logic [DIM_W-1:0]   width_reg;
		logic [DIM_W-1:0]   height_reg;
		logic [SHIFT_W-1:0] shift_reg;
		logic [PIX_W-1:0]   row_older [LINE_DEPTH];
		logic [PIX_W-1:0]   row_newer [LINE_DEPTH];
		logic [PIX_W-1:0]   win [9];
		int unsigned        rx_count;
		int unsigned        tx_count;
		int                 frames_done;
		int                 items_taken;
		int                 outputs_seen;
		int                 errors;
		blur_px_t           pending_px [$];

		function new();
			width_reg    = WIDTH_RST;
			height_reg   = HEIGHT_RST;
			shift_reg    = SHIFT_RST;
			rx_count     = 0;
			tx_count     = 0;
			frames_done  = 0;
			items_taken  = 0;
			outputs_seen = 0;
			errors       = 0;
			foreach (row_older[i]) begin
				row_older[i] = '0;
				row_newer[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				REG_WIDTH:  width_reg  = data[DIM_W-1:0];
				REG_HEIGHT: height_reg = data[DIM_W-1:0];
				REG_SHIFT:  shift_reg  = data[SHIFT_W-1:0];
				default: ;
			endcase
		endfunction

		// Zero behaves as one, anything above the maximum as the maximum.
		function int unsigned geom_limit(logic [DIM_W-1:0] v, int unsigned ceiling);
			if (v == 0) return 1;
			if (v > ceiling) return ceiling;
			return v;
		endfunction

		function int unsigned row_len();
			return geom_limit(width_reg, LINE_DEPTH);
		endfunction

		function int unsigned frame_pixels();
			return row_len() * geom_limit(height_reg, ROW_LIMIT);
		endfunction

		function bit in_flush();
			return rx_count >= frame_pixels();
		endfunction

		// Advances the filter by one accepted transfer and queues the pixel
		// that it releases, if any. Returns 0 for a drain that is dropped.
		function bit convolve_item(blur_cmd_e cmd_in, logic [PIX_W-1:0] px_in);
			int unsigned w, h, total, p, col, q, orow, ocol, acc;
			logic [PIX_W-1:0] px;
			blur_px_t res;
			w     = row_len();
			h     = geom_limit(height_reg, ROW_LIMIT);
			total = w * h;
			p     = rx_count;
			px    = px_in;
			if (p >= total) begin
				px = '0;
			end else if (cmd_in == CMD_DRAIN) begin
				return 0;
			end
			items_taken++;

			col = p % w;
			for (int r = 0; r < 3; r++) begin
				win[r*3]   = win[r*3+1];
				win[r*3+1] = win[r*3+2];
			end
			win[2] = row_older[col];
			win[5] = row_newer[col];
			win[8] = px;
			row_older[col] = row_newer[col];
			row_newer[col] = px;
			rx_count = (p + 1) & 32'h1F_FFFF;

			if (p < w + 1) return 1;
			q = p - w - 1;
			if (q >= total) begin
				rx_count = 0;
				tx_count = 0;
				frames_done++;
				return 1;
			end

			orow = q / w;
			ocol = q % w;
			acc  = 0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (r == 0 && orow == 0) continue;
					if (r == 2 && orow + 1 >= h) continue;
					if (c == 0 && ocol == 0) continue;
					if (c == 2 && ocol + 1 >= w) continue;
					acc += win[r*3+c] * (r == 1 ? 2 : 1) * (c == 1 ? 2 : 1);
				end
			end
			res.filtered = FILT_W'(acc >> shift_reg);
			res.last     = (q + 1 == total);
			if (res.last) begin
				rx_count = 0;
				tx_count = 0;
				frames_done++;
			end else begin
				tx_count = (q + 1) & 32'h1F_FFFF;
			end
			pending_px.push_back(res);
			return 1;
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_output(logic [FILT_W-1:0] f, logic l);
			blur_px_t want;
			if (pending_px.size() == 0) begin
				report($sformatf("output %0d (filtered %0d last %0b) with nothing pending",
					outputs_seen, f, l));
			end else begin
				want = pending_px.pop_front();
				if (f !== want.filtered)
					report($sformatf("output %0d filtered %0d, want %0d",
						outputs_seen, f, want.filtered));
				if (l !== want.last)
					report($sformatf("output %0d last %0b, want %0b",
						outputs_seen, l, want.last));
			end
			outputs_seen++;
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, DUT and channels
	// ------------------------------------------------------------------------
	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gb3_pix_in_if  pix_in_ch ();
	gb3_pix_out_if pix_out_ch ();

	gaussian_blur_3x3_stream u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in_ch),
		.pix_out (pix_out_ch)
	);

	blur_checker blur_model = new();

	// When set, the matching side runs with no idling at all.
	bit src_calm;
	bit sink_calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle lengths: mostly none or a few cycles, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (src_calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_stall();
		int r;
		r = $urandom_range(0, 99);
		if (sink_calm || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Pixel values lean toward the two extremes so that saturated sums and
	// all-zero neighborhoods show up often.
	function automatic logic [PIX_W-1:0] pick_pixel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return PIX_W'($urandom());
	endfunction

	function automatic logic [DATA_W-1:0] field_mask(logic [IDX_W-1:0] idx);
		case (idx)
			REG_WIDTH, REG_HEIGHT: return (DATA_W'(1) << DIM_W) - 1;
			REG_SHIFT:             return (DATA_W'(1) << SHIFT_W) - 1;
			default:               return '0;
		endcase
	endfunction

	function automatic int unsigned rand_width();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r == 1) return 1;
		if (r < 16) return $urandom_range(2, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic int unsigned rand_height();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 0;
		if (r < 17) return $urandom_range(1, 8);
		return $urandom_range(9, 16);
	endfunction

	// ------------------------------------------------------------------------
	// Register access. Every task is entered just after a rising edge and
	// returns just after one, so the bus phases line up with the clock.
	// ------------------------------------------------------------------------
	task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		blur_model.set_reg(idx, data);
	endtask

	task automatic reg_read(input logic [IDX_W-1:0] idx, output logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic verify_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] want);
		logic [DATA_W-1:0] got;
		reg_read(idx, got);
		if (got !== want)
			blur_model.report($sformatf("register %0d reads %0h, want %0h", idx, got, want));
	endtask

	// Writes a register with junk in the unused upper bits, then reads it
	// back: only the field itself should stick.
	task automatic set_register(input logic [IDX_W-1:0] idx, input int unsigned val);
		logic [DATA_W-1:0] fmask;
		logic [DATA_W-1:0] data;
		fmask = field_mask(idx);
		data  = (DATA_W'($urandom()) & ~fmask) | (DATA_W'(val) & fmask);
		reg_write(idx, data);
		verify_reg(idx, data & fmask);
	endtask

	task automatic set_geometry(input int unsigned w, input int unsigned h,
		input int unsigned sh);
		set_register(REG_WIDTH, w);
		set_register(REG_HEIGHT, h);
		set_register(REG_SHIFT, sh);
	endtask

	// ------------------------------------------------------------------------
	// Input side. One transfer per call; the model sees the transfer in the
	// same process that observed the handshake, so the frame position that
	// the stimulus reads back is never a cycle stale.
	// ------------------------------------------------------------------------
	task automatic send_item(input blur_cmd_e c, input logic [PIX_W-1:0] px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_ch.valid <= 1'b1;
		pix_in_ch.cmd   <= c;
		pix_in_ch.pixel <= px;
		@(posedge clk);
		while (!pix_in_ch.ready) @(posedge clk);
		void'(blur_model.convolve_item(c, px));
	endtask

	// Drops valid and holds off until every predicted pixel has come out,
	// then gives the pipeline a few more cycles for transfers that release
	// nothing. Configuration writes follow only this.
	task automatic wait_idle();
		pix_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (blur_model.pending_px.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Raw pixels, stopping early if the frame fills up.
	task automatic feed_pixels(input int n);
		repeat (n) begin
			if (!blur_model.in_flush()) send_item(CMD_PIXEL, pick_pixel());
		end
	endtask

	// Runs the current frame to its end. Before the frame is complete a
	// share of the transfers are drains, which the block must drop; after
	// it, drains and pixels both flush. Now and then the sender pauses until
	// the output side has caught up.
	task automatic feed_frame(input int junk_pct);
		int mark;
		mark = blur_model.frames_done;
		while (blur_model.frames_done == mark) begin
			if (blur_model.in_flush())
				send_item($urandom_range(0, 1) ? CMD_DRAIN : CMD_PIXEL, pick_pixel());
			else if ($urandom_range(0, 99) < junk_pct)
				send_item(CMD_DRAIN, pick_pixel());
			else
				send_item(CMD_PIXEL, pick_pixel());
			if ($urandom_range(0, 149) == 0) wait_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// Output side: the ready pattern and the result check.
	// ------------------------------------------------------------------------
	initial begin : sink_side
		int hold;
		hold = 0;
		pix_out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				pix_out_ch.ready <= 1'b0;
			end else begin
				pix_out_ch.ready <= 1'b1;
				hold = pick_stall();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix_out_ch.valid && pix_out_ch.ready)
			blur_model.check_output(pix_out_ch.filtered, pix_out_ch.last);
	end

	// A hang on either channel shows up as a long run of cycles with no
	// transfer at all. The longest legitimate quiet stretch (a long stall
	// stacked on a long gap, or the recount after a geometry write) is far
	// below the limit.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_in_ch.valid && pix_in_ch.ready) ||
				(pix_out_ch.valid && pix_out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		// A 4x3 frame whose left three columns are full scale, so that the
		// interior pixel in their middle reaches the largest possible sum.
		logic [PIX_W-1:0] frame_a [12] = '{
			8'd255, 8'd255, 8'd255, 8'd0,
			8'd255, 8'd255, 8'd255, 8'h5A,
			8'd255, 8'd255, 8'd255, 8'hA5
		};
		int start_items;

		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		pix_in_ch.valid  <= 1'b0;
		pix_in_ch.cmd    <= CMD_PIXEL;
		pix_in_ch.pixel  <= '0;
		src_calm          = 1'b0;
		sink_calm         = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers must come out of reset at their documented values.
		verify_reg(REG_WIDTH, DATA_W'(WIDTH_RST));
		verify_reg(REG_HEIGHT, DATA_W'(HEIGHT_RST));
		verify_reg(REG_SHIFT, DATA_W'(SHIFT_RST));

		// Directed: saturated sum with no shift, a drain in the middle of
		// the frame that must be dropped, and a flush that mixes drains
		// with pixel transfers whose values must be discarded.
		set_geometry(4, 3, 0);
		for (int i = 0; i < 12; i++) begin
			send_item(CMD_PIXEL, frame_a[i]);
			if (i == 5) send_item(CMD_DRAIN, 8'hFF);
		end
		send_item(CMD_DRAIN, 8'h00);
		send_item(CMD_PIXEL, 8'h3C);
		send_item(CMD_DRAIN, 8'hC3);
		send_item(CMD_PIXEL, 8'hFF);
		send_item(CMD_DRAIN, 8'h81);
		wait_idle();

		// Zero width and zero height both behave as one: a single pixel
		// frame, here with a shift of 12.
		set_geometry(0, 0, 12);
		send_item(CMD_PIXEL, 8'd255);
		send_item(CMD_DRAIN, 8'd0);
		send_item(CMD_DRAIN, 8'd0);
		wait_idle();

		// Oversized width clamps to the full line; this one row frame also
		// writes every line store entry, so later geometry changes in the
		// middle of a frame never read an entry that holds nothing.
		set_geometry(2047, 0, 4);
		feed_frame(5);
		wait_idle();

		// Oversized height clamps likewise, one column wide, full shift.
		set_geometry(0, 2047, 15);
		feed_frame(5);
		wait_idle();

		// Geometry changed mid-frame. Shrinking the height so that the next
		// output lies past the new frame re-arms the counters with no
		// pixel; then a normal frame at the new size.
		set_geometry(8, 6, 3);
		feed_pixels(30);
		wait_idle();
		set_register(REG_HEIGHT, 2);
		feed_frame(0);
		feed_frame(10);
		wait_idle();

		// Narrowing the row part way through, and growing the height.
		set_register(REG_HEIGHT, 6);
		feed_pixels(20);
		wait_idle();
		set_register(REG_WIDTH, 5);
		feed_frame(10);
		wait_idle();
		set_geometry(6, 2, 1);
		feed_pixels(9);
		wait_idle();
		set_register(REG_HEIGHT, 4);
		feed_frame(10);
		wait_idle();

		// Random phases: a fresh mix of registers each time, one to three
		// frames, sometimes with a geometry change in the middle of one.
		start_items = blur_model.items_taken;
		while (blur_model.items_taken - start_items < RANDOM_ITEMS) begin
			src_calm  = ($urandom_range(0, 4) == 0);
			sink_calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 7) set_register(REG_WIDTH, rand_width());
			if ($urandom_range(0, 9) < 7) set_register(REG_HEIGHT, rand_height());
			if ($urandom_range(0, 9) < 7) set_register(REG_SHIFT, $urandom_range(0, 15));
			if ($urandom_range(0, 5) == 0) begin
				feed_pixels($urandom_range(1, blur_model.frame_pixels()));
				wait_idle();
				if ($urandom_range(0, 1))
					set_register(REG_WIDTH, rand_width());
				else
					set_register(REG_HEIGHT, rand_height());
			end
			repeat ($urandom_range(1, 3)) feed_frame($urandom_range(0, 15));
			wait_idle();
		end

		// Everything predicted has arrived; give the block a little longer
		// to show any stray output before deciding.
		repeat (20) @(posedge clk);
		if (blur_model.errors == 0 && blur_model.pending_px.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
